// File: sv/tpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

  // coordinate differences formed in the first stage
  localparam int NUM_DIFF = 16;

  typedef enum logic [3:0] {
    DIF_BAX,  // b - a
    DIF_BAY,
    DIF_CAX,  // c - a
    DIF_CAY,
    DIF_QX,   // p - a
    DIF_QY,
    DIF_CBX,  // c - b
    DIF_CBY,
    DIF_PBX,  // p - b
    DIF_PBY,
    DIF_ADX,  // a - p
    DIF_ADY,
    DIF_BDX,  // b - p
    DIF_BDY,
    DIF_CDX,  // c - p
    DIF_CDY
  } tpq_diff_idx_t;

  // number of incircle determinant terms (one per vertex lift)
  localparam int NUM_TERM = 3;

  typedef struct packed {
    logic in_tri;
    logic orient_pos;
    logic degen;
  } tpq_flags_t;

  typedef struct packed {
    logic inside_triangle;
    logic inside_circle;
    logic degenerate;
  } tpq_result_t;

endpackage

`default_nettype wire

// File: sv/tpq_delta.sv
`timescale 1ns / 1ps
`default_nettype none

module tpq_delta
  import tpq_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] a_x,
  input  wire logic signed [COORD_WIDTH-1:0] a_y,
  input  wire logic signed [COORD_WIDTH-1:0] b_x,
  input  wire logic signed [COORD_WIDTH-1:0] b_y,
  input  wire logic signed [COORD_WIDTH-1:0] c_x,
  input  wire logic signed [COORD_WIDTH-1:0] c_y,
  input  wire logic signed [COORD_WIDTH-1:0] p_x,
  input  wire logic signed [COORD_WIDTH-1:0] p_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH:0]        diff_o [NUM_DIFF]
);

  localparam int DW = COORD_WIDTH + 1;

  logic                 vld_r;
  logic signed [DW-1:0] diff_nxt [NUM_DIFF];
  logic signed [DW-1:0] diff_r   [NUM_DIFF];

  always_comb begin
    diff_nxt[DIF_BAX] = DW'(b_x) - DW'(a_x);
    diff_nxt[DIF_BAY] = DW'(b_y) - DW'(a_y);
    diff_nxt[DIF_CAX] = DW'(c_x) - DW'(a_x);
    diff_nxt[DIF_CAY] = DW'(c_y) - DW'(a_y);
    diff_nxt[DIF_QX]  = DW'(p_x) - DW'(a_x);
    diff_nxt[DIF_QY]  = DW'(p_y) - DW'(a_y);
    diff_nxt[DIF_CBX] = DW'(c_x) - DW'(b_x);
    diff_nxt[DIF_CBY] = DW'(c_y) - DW'(b_y);
    diff_nxt[DIF_PBX] = DW'(p_x) - DW'(b_x);
    diff_nxt[DIF_PBY] = DW'(p_y) - DW'(b_y);
    diff_nxt[DIF_ADX] = DW'(a_x) - DW'(p_x);
    diff_nxt[DIF_ADY] = DW'(a_y) - DW'(p_y);
    diff_nxt[DIF_BDX] = DW'(b_x) - DW'(p_x);
    diff_nxt[DIF_BDY] = DW'(b_y) - DW'(p_y);
    diff_nxt[DIF_CDX] = DW'(c_x) - DW'(p_x);
    diff_nxt[DIF_CDY] = DW'(c_y) - DW'(p_y);
  end

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign diff_o    = diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      diff_r <= diff_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/tpq_cross.sv
`timescale 1ns / 1ps
`default_nettype none

module tpq_cross
  import tpq_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [COORD_WIDTH:0]     diff_i [NUM_DIFF],
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output tpq_flags_t                           flags_o,
  output logic signed [2*COORD_WIDTH+2:0]      minor_o [NUM_TERM],
  output logic signed [2*COORD_WIDTH+2:0]      lift_o  [NUM_TERM]
);

  localparam int DW       = COORD_WIDTH + 1;
  localparam int PW       = 2 * DW;
  localparam int MW       = PW + 1;
  localparam int NUM_PROD = 20;

  typedef enum logic [4:0] {
    PR_T0, PR_T1, PR_T2, PR_T3, PR_T4, PR_T5,  // same-side crosses
    PR_O0, PR_O1,                              // orientation
    PR_M0, PR_M1, PR_M2, PR_M3, PR_M4, PR_M5,  // 2x2 minors
    PR_SAX, PR_SAY, PR_SBX, PR_SBY, PR_SCX, PR_SCY  // squares for lifts
  } prod_idx_t;

  logic                 vld_a_r;
  logic                 vld_b_r;
  logic                 adv_a;
  logic                 adv_b;
  logic signed [PW-1:0] prod_nxt [NUM_PROD];
  logic signed [PW-1:0] prod_r   [NUM_PROD];

  logic signed [MW-1:0] cross_ab;
  logic signed [MW-1:0] cross_ac;
  logic signed [MW-1:0] cross_bc;
  logic signed [MW-1:0] orient;
  logic                 s_ab;
  logic                 s_ac;
  logic                 s_bc;
  tpq_flags_t           flags_nxt;
  tpq_flags_t           flags_r;
  logic signed [MW-1:0] minor_nxt [NUM_TERM];
  logic signed [MW-1:0] minor_r   [NUM_TERM];
  logic signed [MW-1:0] lift_nxt  [NUM_TERM];
  logic signed [MW-1:0] lift_r    [NUM_TERM];

  // stage a: one multiplier per product
  always_comb begin
    prod_nxt[PR_T0]  = PW'(diff_i[DIF_BAX]) * PW'(diff_i[DIF_QY]);
    prod_nxt[PR_T1]  = PW'(diff_i[DIF_BAY]) * PW'(diff_i[DIF_QX]);
    prod_nxt[PR_T2]  = PW'(diff_i[DIF_CAX]) * PW'(diff_i[DIF_QY]);
    prod_nxt[PR_T3]  = PW'(diff_i[DIF_CAY]) * PW'(diff_i[DIF_QX]);
    prod_nxt[PR_T4]  = PW'(diff_i[DIF_CBX]) * PW'(diff_i[DIF_PBY]);
    prod_nxt[PR_T5]  = PW'(diff_i[DIF_CBY]) * PW'(diff_i[DIF_PBX]);
    prod_nxt[PR_O0]  = PW'(diff_i[DIF_BAX]) * PW'(diff_i[DIF_CAY]);
    prod_nxt[PR_O1]  = PW'(diff_i[DIF_BAY]) * PW'(diff_i[DIF_CAX]);
    prod_nxt[PR_M0]  = PW'(diff_i[DIF_BDX]) * PW'(diff_i[DIF_CDY]);
    prod_nxt[PR_M1]  = PW'(diff_i[DIF_CDX]) * PW'(diff_i[DIF_BDY]);
    prod_nxt[PR_M2]  = PW'(diff_i[DIF_CDX]) * PW'(diff_i[DIF_ADY]);
    prod_nxt[PR_M3]  = PW'(diff_i[DIF_ADX]) * PW'(diff_i[DIF_CDY]);
    prod_nxt[PR_M4]  = PW'(diff_i[DIF_ADX]) * PW'(diff_i[DIF_BDY]);
    prod_nxt[PR_M5]  = PW'(diff_i[DIF_BDX]) * PW'(diff_i[DIF_ADY]);
    prod_nxt[PR_SAX] = PW'(diff_i[DIF_ADX]) * PW'(diff_i[DIF_ADX]);
    prod_nxt[PR_SAY] = PW'(diff_i[DIF_ADY]) * PW'(diff_i[DIF_ADY]);
    prod_nxt[PR_SBX] = PW'(diff_i[DIF_BDX]) * PW'(diff_i[DIF_BDX]);
    prod_nxt[PR_SBY] = PW'(diff_i[DIF_BDY]) * PW'(diff_i[DIF_BDY]);
    prod_nxt[PR_SCX] = PW'(diff_i[DIF_CDX]) * PW'(diff_i[DIF_CDX]);
    prod_nxt[PR_SCY] = PW'(diff_i[DIF_CDY]) * PW'(diff_i[DIF_CDY]);
  end

  // stage b: pairwise differences and sums, sign tests
  always_comb begin
    cross_ab = MW'(prod_r[PR_T0]) - MW'(prod_r[PR_T1]);
    cross_ac = MW'(prod_r[PR_T2]) - MW'(prod_r[PR_T3]);
    cross_bc = MW'(prod_r[PR_T4]) - MW'(prod_r[PR_T5]);
    orient   = MW'(prod_r[PR_O0]) - MW'(prod_r[PR_O1]);

    s_ab = !cross_ab[MW-1] && (cross_ab != '0);
    s_ac = !cross_ac[MW-1] && (cross_ac != '0);
    s_bc = !cross_bc[MW-1] && (cross_bc != '0);

    flags_nxt.in_tri     = (s_ac != s_ab) && (s_bc == s_ab);
    flags_nxt.orient_pos = !orient[MW-1] && (orient != '0);
    flags_nxt.degen      = (orient == '0);

    // cofactor of each lift in the incircle determinant
    minor_nxt[0] = MW'(prod_r[PR_M0]) - MW'(prod_r[PR_M1]);
    minor_nxt[1] = MW'(prod_r[PR_M2]) - MW'(prod_r[PR_M3]);
    minor_nxt[2] = MW'(prod_r[PR_M4]) - MW'(prod_r[PR_M5]);

    lift_nxt[0] = MW'(prod_r[PR_SAX]) + MW'(prod_r[PR_SAY]);
    lift_nxt[1] = MW'(prod_r[PR_SBX]) + MW'(prod_r[PR_SBY]);
    lift_nxt[2] = MW'(prod_r[PR_SCX]) + MW'(prod_r[PR_SCY]);
  end

  assign adv_b     = !vld_b_r || out_ready;
  assign adv_a     = !vld_a_r || adv_b;
  assign in_ready  = adv_a;
  assign out_valid = vld_b_r;
  assign flags_o   = flags_r;
  assign minor_o   = minor_r;
  assign lift_o    = lift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (adv_a) begin
        vld_a_r <= in_valid;
      end
      if (adv_b) begin
        vld_b_r <= vld_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      prod_r <= prod_nxt;
    end
    if (adv_b) begin
      flags_r <= flags_nxt;
      minor_r <= minor_nxt;
      lift_r  <= lift_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/tpq_incircle.sv
`timescale 1ns / 1ps
`default_nettype none

module tpq_incircle
  import tpq_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire tpq_flags_t                      flags_i,
  input  wire logic signed [2*COORD_WIDTH+2:0] minor_i [NUM_TERM],
  input  wire logic signed [2*COORD_WIDTH+2:0] lift_i  [NUM_TERM],
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output tpq_result_t                          result_o
);

  localparam int DW  = COORD_WIDTH + 1;   // split point of the wide operands
  localparam int MW  = 2 * DW + 1;        // minor and lift width
  localparam int HW  = MW - DW;           // upper slice width
  localparam int LLW = 2 * DW;            // low x low partial product
  localparam int QW  = 2 * HW;            // partial products with an upper slice
  localparam int TW  = 4 * DW + 2;        // determinant width

  logic vld_a_r;
  logic vld_b_r;
  logic vld_c_r;
  logic adv_a;
  logic adv_b;
  logic adv_c;

  logic signed [HW-1:0]  m_hi [NUM_TERM];
  logic signed [HW-1:0]  m_lo [NUM_TERM];
  logic signed [HW-1:0]  l_hi [NUM_TERM];
  logic signed [HW-1:0]  l_lo [NUM_TERM];
  logic        [DW-1:0]  m_lo_u [NUM_TERM];
  logic        [DW-1:0]  l_lo_u [NUM_TERM];

  logic        [LLW-1:0] ll_nxt [NUM_TERM];
  logic        [LLW-1:0] ll_r   [NUM_TERM];
  logic signed [QW-1:0]  hl_nxt [NUM_TERM];
  logic signed [QW-1:0]  hl_r   [NUM_TERM];
  logic signed [QW-1:0]  lh_nxt [NUM_TERM];
  logic signed [QW-1:0]  lh_r   [NUM_TERM];
  logic signed [QW-1:0]  hh_nxt [NUM_TERM];
  logic signed [QW-1:0]  hh_r   [NUM_TERM];
  tpq_flags_t            flags_a_r;

  logic signed [TW-1:0]  ll_x [NUM_TERM];
  logic signed [TW-1:0]  term_nxt [NUM_TERM];
  logic signed [TW-1:0]  term_r   [NUM_TERM];
  tpq_flags_t            flags_b_r;

  logic signed [TW-1:0]  det;
  logic                  det_ok;
  tpq_result_t           result_nxt;
  tpq_result_t           result_r;

  // stage a: each minor times lift as four narrow partial products
  always_comb begin
    for (int k = 0; k < NUM_TERM; k++) begin
      m_lo_u[k] = minor_i[k][DW-1:0];
      l_lo_u[k] = lift_i[k][DW-1:0];
      m_hi[k]   = $signed(minor_i[k][MW-1:DW]);
      l_hi[k]   = $signed(lift_i[k][MW-1:DW]);
      m_lo[k]   = $signed({1'b0, m_lo_u[k]});
      l_lo[k]   = $signed({1'b0, l_lo_u[k]});
      ll_nxt[k] = LLW'(m_lo_u[k]) * LLW'(l_lo_u[k]);
      hl_nxt[k] = QW'(m_hi[k]) * QW'(l_lo[k]);
      lh_nxt[k] = QW'(m_lo[k]) * QW'(l_hi[k]);
      hh_nxt[k] = QW'(m_hi[k]) * QW'(l_hi[k]);
    end
  end

  // stage b: recombine partial products per term
  always_comb begin
    for (int k = 0; k < NUM_TERM; k++) begin
      ll_x[k]     = TW'(ll_r[k]);
      term_nxt[k] = (TW'(hh_r[k]) <<< (2 * DW))
                  + ((TW'(hl_r[k]) + TW'(lh_r[k])) <<< DW)
                  + ll_x[k];
    end
  end

  // stage c: determinant sign against orientation
  always_comb begin
    det    = term_r[0] + term_r[1] + term_r[2];
    det_ok = flags_b_r.orient_pos ? !det[TW-1] : (det[TW-1] || (det == '0));
    result_nxt.inside_triangle = flags_b_r.in_tri;
    result_nxt.inside_circle   = !flags_b_r.degen && det_ok;
    result_nxt.degenerate      = flags_b_r.degen;
  end

  assign adv_c     = !vld_c_r || out_ready;
  assign adv_b     = !vld_b_r || adv_c;
  assign adv_a     = !vld_a_r || adv_b;
  assign in_ready  = adv_a;
  assign out_valid = vld_c_r;
  assign result_o  = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else begin
      if (adv_a) begin
        vld_a_r <= in_valid;
      end
      if (adv_b) begin
        vld_b_r <= vld_a_r;
      end
      if (adv_c) begin
        vld_c_r <= vld_b_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      ll_r      <= ll_nxt;
      hl_r      <= hl_nxt;
      lh_r      <= lh_nxt;
      hh_r      <= hh_nxt;
      flags_a_r <= flags_i;
    end
    if (adv_b) begin
      term_r    <= term_nxt;
      flags_b_r <= flags_a_r;
    end
    if (adv_c) begin
      result_r  <= result_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/triangle_point_query.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted request passes the delta, cross and incircle stages to its result on the output register
// throughput: one request per cycle unless out_ready stalls it, the 20 difference multipliers and 12 partial
//   product multipliers each sit in a stage of their own
// reset: synchronous active-low rst_n clears every stage valid bit, payload is not reset
module triangle_point_query
  import tpq_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_vertex_a_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_vertex_a_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_vertex_b_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_vertex_b_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_vertex_c_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_vertex_c_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_inside_triangle,
  output logic                               out_inside_circle,
  output logic                               out_degenerate
);

  // stage plan
  //   1  delta:    sixteen coordinate differences
  //   2  cross:    products of differences (crosses, minors, squares)
  //   3  cross:    cross signs, orientation, minors and lifts
  //   4  incircle: minor x lift split into narrow partial products
  //   5  incircle: partial products recombined per term
  //   6  incircle: determinant sum, orientation-corrected sign, output register
  // each stage loads when it is empty or the stage after it moves, so a
  // stalled output only backs up as far as the first empty stage

  localparam int DW = COORD_WIDTH + 1;
  localparam int MW = 2 * DW + 1;

  // delta -> cross
  logic                 dlt_valid;
  logic                 dlt_ready;
  logic signed [DW-1:0] dlt_diff [NUM_DIFF];

  // cross -> incircle
  logic                 crs_valid;
  logic                 crs_ready;
  tpq_flags_t           crs_flags;
  logic signed [MW-1:0] crs_minor [NUM_TERM];
  logic signed [MW-1:0] crs_lift  [NUM_TERM];

  tpq_result_t          result;

  tpq_delta #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_delta (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .a_x       (in_vertex_a_x),
    .a_y       (in_vertex_a_y),
    .b_x       (in_vertex_b_x),
    .b_y       (in_vertex_b_y),
    .c_x       (in_vertex_c_x),
    .c_y       (in_vertex_c_y),
    .p_x       (in_point_x),
    .p_y       (in_point_y),
    .out_valid (dlt_valid),
    .out_ready (dlt_ready),
    .diff_o    (dlt_diff)
  );

  // same-side crosses, orientation and the incircle cofactors
  tpq_cross #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dlt_valid),
    .in_ready  (dlt_ready),
    .diff_i    (dlt_diff),
    .out_valid (crs_valid),
    .out_ready (crs_ready),
    .flags_o   (crs_flags),
    .minor_o   (crs_minor),
    .lift_o    (crs_lift)
  );

  // exact incircle determinant; a point on the circle counts as inside,
  // collinear vertices force the circle flag low
  tpq_incircle #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_incircle (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (crs_valid),
    .in_ready  (crs_ready),
    .flags_i   (crs_flags),
    .minor_i   (crs_minor),
    .lift_i    (crs_lift),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_o  (result)
  );

  assign out_inside_triangle = result.inside_triangle;
  assign out_inside_circle   = result.inside_circle;
  assign out_degenerate      = result.degenerate;

endmodule

`default_nettype wire
